### hdl/adc_manchester_byte_decoder_top_assert.svh
// Assertion macros for the ADC Manchester byte decoder.
// Used by adc_manchester_byte_decoder_top; expects aclk and aresetn in scope.
`ifndef ADC_MANCHESTER_BYTE_DECODER_TOP_ASSERT_SVH
`define ADC_MANCHESTER_BYTE_DECODER_TOP_ASSERT_SVH

// Clocked check, disabled while reset is asserted
`define AMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds through reset
`define AMD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### hdl/amd_pkg.sv
// Package for the ADC Manchester byte decoder: widths, reset values, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package amd_pkg;

    // Field and register widths
    localparam int THRESHOLD_W = 12;
    localparam int SYMBOL_W    = 6;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 12;

    // Default sample width
    localparam int SAMPLE_BITS_DEFAULT = 12;

    // Register reset values
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 12'd2049;
    localparam logic [SYMBOL_W-1:0]    SYMBOL_RESET    = 6'd6;

    // Bit count of the last bit in a byte
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = 3'd7;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_THRESHOLD    = 8'd0,
        CFG_SAMPLES_PER_SYMBOL = 8'd1
    } cfg_index_t;

endpackage

### hdl/adc_manchester_byte_decoder_top.sv
// ADC Manchester byte decoder, top level.
// Depends on amd_pkg and adc_manchester_byte_decoder_top_assert.svh.
`timescale 1ns / 1ps
`include "adc_manchester_byte_decoder_top_assert.svh"

// Decodes a Manchester line from a stream of ADC samples, one sample per transfer.
// Each sample and the one before it are compared strictly against level_threshold;
// a low-to-high crossing holds a 0 and a high-to-low crossing holds a 1. Every
// samples_per_symbol samples (0 acts as 1) the held bit shifts into a byte, MSB
// first, and every eighth bit a finished byte is offered on the m_ channel. The
// block takes one sample per clock while no unread byte blocks the result register: a
// sample lands in the input register, then the decode step updates the line state and
// loads the result register, so a byte is presented on m_valid once its last sample
// has passed the input register and the decode step. The flow stalls only while an unread
// byte blocks the result register. Configuration writes are accepted in any cycle and
// belong to idle periods.
module adc_manchester_byte_decoder_top
    import amd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // sample channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_adc_sample,
    // byte channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [BYTE_W-1:0]      m_decoded_byte,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Compare width covers both sample and threshold
    localparam int CMP_W = (SAMPLE_BITS > THRESHOLD_W) ? SAMPLE_BITS : THRESHOLD_W;

    // Configuration registers
    logic [THRESHOLD_W-1:0] threshold_reg;
    logic [SYMBOL_W-1:0]    sps_reg;

    // Input stage
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    // Line state
    logic [SAMPLE_BITS-1:0] prev_sample_reg;
    logic                   held_bit_reg;
    logic [SYMBOL_W-1:0]    sample_cnt_reg;
    logic [BYTE_W-1:0]      shifter_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;

    // Result stage
    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      out_byte_reg;

    // Decode step signals
    logic                   advance;
    logic [CMP_W-1:0]       cur_ext;
    logic [CMP_W-1:0]       prev_ext;
    logic [CMP_W-1:0]       thr_ext;
    logic                   held_bit_next;
    logic [SYMBOL_W:0]      cnt_plus;
    logic                   sym_end;
    logic                   byte_done;
    logic                   byte_load;
    logic                   mid_symbol;
    logic                   in_stall;
    logic [BYTE_W-1:0]      shifter_shifted;
    logic [SYMBOL_W-1:0]    sample_cnt_next;
    logic [BYTE_W-1:0]      shifter_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_next;

    // Handshakes
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign in_stall  = in_valid_reg && !advance;

    assign m_valid        = out_valid_reg;
    assign m_decoded_byte = out_byte_reg;

    // Crossing detection against the threshold
    assign cur_ext  = CMP_W'(in_sample_reg);
    assign prev_ext = CMP_W'(prev_sample_reg);
    assign thr_ext  = CMP_W'(threshold_reg);

    always_comb begin
        held_bit_next = held_bit_reg;
        if (cur_ext > thr_ext && prev_ext < thr_ext) begin
            held_bit_next = 1'b0;
        end else if (cur_ext < thr_ext && prev_ext > thr_ext) begin
            held_bit_next = 1'b1;
        end
    end

    // Symbol and bit counting; a zero symbol length ends every symbol
    assign cnt_plus        = {1'b0, sample_cnt_reg} + (SYMBOL_W+1)'(1);
    assign sym_end         = (cnt_plus >= {1'b0, sps_reg});
    assign byte_done       = sym_end && (bit_cnt_reg == BIT_CNT_LAST);
    assign byte_load       = advance && byte_done;
    assign mid_symbol      = advance && !sym_end;
    assign shifter_shifted = {shifter_reg[BYTE_W-2:0], held_bit_next};

    always_comb begin
        sample_cnt_next = cnt_plus[SYMBOL_W-1:0];
        shifter_next    = shifter_reg;
        bit_cnt_next    = bit_cnt_reg;
        if (sym_end) begin
            sample_cnt_next = '0;
            if (byte_done) begin
                shifter_next = '0;
                bit_cnt_next = '0;
            end else begin
                shifter_next = shifter_shifted;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
            end
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            sps_reg       <= SYMBOL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LEVEL_THRESHOLD: begin
                    threshold_reg <= cfg_data[THRESHOLD_W-1:0];
                end
                CFG_SAMPLES_PER_SYMBOL: begin
                    sps_reg <= cfg_data[SYMBOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_adc_sample;
        end
    end

    // Line state update, one sample per advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= '0;
            held_bit_reg    <= 1'b0;
            sample_cnt_reg  <= '0;
            shifter_reg     <= '0;
            bit_cnt_reg     <= '0;
        end else if (advance) begin
            prev_sample_reg <= in_sample_reg;
            held_bit_reg    <= held_bit_next;
            sample_cnt_reg  <= sample_cnt_next;
            shifter_reg     <= shifter_next;
            bit_cnt_reg     <= bit_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= byte_done;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_load) begin
            out_byte_reg <= shifter_shifted;
        end
    end

    // Checks
    `AMD_ASSERT(a_byte_from_done, $rose(out_valid_reg) |-> $past(byte_load), "byte without source")
    `AMD_ASSERT(a_byte_clear, byte_load |=> !(|{bit_cnt_reg, shifter_reg}), "byte not cleared")
    `AMD_ASSERT(a_bits_hold, mid_symbol |=> $stable({bit_cnt_reg, shifter_reg}), "bit moved early")
    `AMD_ASSERT(a_input_held, in_stall |=> $stable({in_valid_reg, in_sample_reg}), "sample lost")
    `AMD_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !(in_valid_reg || out_valid_reg), "not idle")

endmodule

### bench/adc_manchester_byte_decoder_top_tb.sv
// Self-checking bench for adc_manchester_byte_decoder_top: sample stream in, decoded bytes out.
// Depends on amd_pkg and the top level; a bit-exact line decoder model predicts every byte.
`timescale 1ns / 1ps

module adc_manchester_byte_decoder_top_tb;
    import amd_pkg::*;

    localparam int SAMPLE_W     = SAMPLE_BITS_DEFAULT;
    localparam int DRAIN_CYCLES = 6;        // sample register plus decode step, with margin
    localparam int DRAIN_LIMIT  = 20000;    // cycles allowed for a phase to empty out
    localparam longint TIMEOUT_NS = 64'd5_000_000;
    localparam int PHASE_COUNT  = 12;

    // Indexes outside the register file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_LAST  = 8'hFF;

    // Per-phase settings; a negative threshold is drawn at random
    int phase_threshold [PHASE_COUNT] = '{1000, 0, 4095, 2048, -1, -1, 1, 4094, -1, -1, -1, -1};
    int phase_symbol    [PHASE_COUNT] = '{1, 2, 3, 0, 1, 63, 2, 1, 4, 2, 1, 6};
    int phase_samples   [PHASE_COUNT] = '{64, 64, 64, 64, 64, 130, 64, 64, 64, 64, 64, 64};

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_adc_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BYTE_W-1:0]     m_decoded_byte;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Decoder state mirrored by the bench
    logic [THRESHOLD_W-1:0] line_threshold = THRESHOLD_RESET;
    logic [SYMBOL_W-1:0]    symbol_len     = SYMBOL_RESET;
    logic [SAMPLE_W-1:0]    prev_level     = '0;
    logic                   held_value     = 1'b0;
    logic [SYMBOL_W-1:0]    symbol_pos     = '0;
    logic [BYTE_W-1:0]      byte_shift     = '0;
    logic [BIT_CNT_W-1:0]   bits_in_byte   = '0;

    logic [SAMPLE_W-1:0] pending_samples [$];
    logic [BYTE_W-1:0]   expected_bytes [$];

    int  send_gap_pct   = 0;
    int  stall_pct      = 0;
    bit  hold_samples   = 1'b0;
    int  phase_left     = 0;
    int  samples_sent   = 0;
    int  bytes_checked  = 0;
    int  config_writes  = 0;
    int  fail_count     = 0;

    adc_manchester_byte_decoder_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_adc_sample   (s_adc_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_decoded_byte (m_decoded_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 125 MHz clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // One decode step: crossing detection, symbol count, byte assembly
    function automatic void decode_sample(input logic [SAMPLE_W-1:0] level);
        logic [SYMBOL_W-1:0] len;
        logic [SYMBOL_W:0]   next_pos;
        len = (symbol_len == '0) ? SYMBOL_W'(1) : symbol_len;
        if (level > line_threshold && prev_level < line_threshold) begin
            held_value = 1'b0;
        end else if (level < line_threshold && prev_level > line_threshold) begin
            held_value = 1'b1;
        end
        next_pos = {1'b0, symbol_pos} + (SYMBOL_W+1)'(1);
        if (next_pos >= {1'b0, len}) begin
            symbol_pos = '0;
            byte_shift = {byte_shift[BYTE_W-2:0], held_value};
            if (bits_in_byte == BIT_CNT_LAST) begin
                expected_bytes.push_back(byte_shift);
                byte_shift   = '0;
                bits_in_byte = '0;
            end else begin
                bits_in_byte = bits_in_byte + BIT_CNT_W'(1);
            end
        end else begin
            symbol_pos = next_pos[SYMBOL_W-1:0];
        end
        prev_level = level;
    endfunction

    // Sample driver: predicts each transfer, then offers the next sample or idles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_sample(s_adc_sample);
                samples_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 && !hold_samples &&
                    $urandom_range(99) >= send_gap_pct) begin
                    s_valid      <= 1'b1;
                    s_adc_sample <= pending_samples.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor: checks each transfer against the oldest predicted byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected decoded byte, expected none, got 0x%02h",
                             $time, m_decoded_byte);
                end else begin
                    logic [BYTE_W-1:0] want;
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (m_decoded_byte !== want) begin
                        fail_count++;
                        $display("%0t: decoded byte mismatch, expected 0x%02h, got 0x%02h",
                                 $time, want, m_decoded_byte);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Register write; the bench copy is updated at the transfer
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LEVEL_THRESHOLD:    line_threshold = value[THRESHOLD_W-1:0];
            CFG_SAMPLES_PER_SYMBOL: symbol_len     = value[SYMBOL_W-1:0];
            default: ;
        endcase
        config_writes++;
    endtask

    // Wait until every predicted byte is out, then let the pipeline settle
    task automatic wait_quiet(input bit with_queue);
        int guard;
        guard = 0;
        @(negedge aclk);
        while (((with_queue && pending_samples.size() != 0) || s_valid ||
                expected_bytes.size() != 0) && guard < DRAIN_LIMIT) begin
            @(negedge aclk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT) begin
            fail_count++;
            if (expected_bytes.size() != 0) begin
                $display("%0t: byte never arrived, expected 0x%02h, got none (%0d missing)",
                         $time, expected_bytes[0], expected_bytes.size());
            end else begin
                $display("%0t: sample stream stuck, expected transfer, got none", $time);
            end
            expected_bytes.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Phase stimulus goes through here so each phase stops at its sample budget
    function automatic void queue_sample(input logic [SAMPLE_W-1:0] level);
        if (phase_left > 0) begin
            pending_samples.push_back(level);
            phase_left--;
        end
    endfunction

    // Random level strictly on one side of the threshold where that side exists
    function automatic logic [SAMPLE_W-1:0] line_level(input bit high,
                                                       input logic [THRESHOLD_W-1:0] thr);
        if (high) begin
            return (thr == '1) ? thr : SAMPLE_W'($urandom_range(4095, thr + 1));
        end
        return (thr == '0) ? thr : SAMPLE_W'($urandom_range(thr - 1, 0));
    endfunction

    // Stimulus sequencer
    initial begin
        logic [THRESHOLD_W-1:0] thr;
        logic [SYMBOL_W-1:0]    len;
        logic [SYMBOL_W-1:0]    upper;
        logic [SAMPLE_W-1:0]    level;
        logic [BYTE_W-1:0]      frame;
        int pick, b, k, half_a, half_b;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: first sample after reset, both extremes, samples on the threshold
        pending_samples = '{12'd4095, 12'd0, 12'd2049, 12'd4095, 12'd2049, 12'd0,
                            12'd2048, 12'd2050, 12'd2050, 12'd2048, 12'hAAA, 12'h555,
                            12'd4095, 12'd2049, 12'd4095, 12'd0};
        wait_quiet(1);

        // Shorter symbol while the counter sits past the new length; upper data bits ignored
        write_register(CFG_SAMPLES_PER_SYMBOL, 12'hFC2);
        pending_samples = '{12'd4095, 12'd0, 12'd2049};
        wait_quiet(1);

        // Zero threshold: nothing is low; zero symbol length acts as one sample per symbol
        write_register(CFG_LEVEL_THRESHOLD, 12'd0);
        write_register(CFG_SAMPLES_PER_SYMBOL, 12'hFC0);
        pending_samples = '{12'd0, 12'd4095, 12'd0, 12'd1};

        for (int i = 0; i < PHASE_COUNT; i++) begin
            wait_quiet(1);
            thr   = (phase_threshold[i] < 0) ? THRESHOLD_W'($urandom_range(4095))
                                             : THRESHOLD_W'(phase_threshold[i]);
            len   = SYMBOL_W'(phase_symbol[i]);
            upper = SYMBOL_W'($urandom_range(63));
            write_register(CFG_LEVEL_THRESHOLD, thr);
            write_register(CFG_SAMPLES_PER_SYMBOL, {upper, len});
            write_register((i % 2) ? CFG_INDEX_SPARE : CFG_INDEX_LAST,
                           CFG_DATA_W'($urandom));

            case (i % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 77; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 77; end
                default: begin send_gap_pct = 30; stall_pct = 30; end
            endcase

            half_a = (len > 1) ? len / 2 : 1;
            half_b = (len > 1) ? len - half_a : 1;
            phase_left = phase_samples[i];
            while (phase_left > 0) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    // Clean frame: a 1 is high then low, a 0 is low then high
                    frame = BYTE_W'($urandom_range(255));
                    for (b = BYTE_W - 1; b >= 0; b--) begin
                        for (k = 0; k < half_a; k++) queue_sample(line_level(frame[b], thr));
                        for (k = 0; k < half_b; k++) queue_sample(line_level(!frame[b], thr));
                    end
                end else if (pick < 85) begin
                    // Full-range noise burst
                    repeat ($urandom_range(8, 1)) queue_sample(SAMPLE_W'($urandom));
                end else begin
                    // Broken symbol: levels on or right next to the threshold
                    repeat ($urandom_range(4, 1)) begin
                        case ($urandom_range(2))
                            0: level = thr;
                            1: level = (thr == '1) ? thr : thr + THRESHOLD_W'(1);
                            default: level = (thr == '0) ? thr : thr - THRESHOLD_W'(1);
                        endcase
                        queue_sample(level);
                    end
                end
            end

            // In the first phase the sender holds off mid-phase until the byte side has caught up
            if (i == 0) begin
                while (pending_samples.size() > phase_samples[i] / 2) @(negedge aclk);
                hold_samples = 1'b1;
                wait_quiet(0);
                hold_samples = 1'b0;
            end
        end

        wait_quiet(1);
        $display("Run covered %0d samples and %0d register writes over %0d phases;",
                 samples_sent, config_writes, PHASE_COUNT);
        $display("%0d decoded bytes checked, %0d errors.", bytes_checked, fail_count);
        if (fail_count == 0) begin
            $display("** adc_manchester_byte_decoder_top: PASSED **");
        end else begin
            $display("** adc_manchester_byte_decoder_top: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout at %0t", $time);
        $display("** adc_manchester_byte_decoder_top: FAILED **");
        $finish;
    end

endmodule
